>>> hdl/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_W     = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CHILD_W   = IDX_W + 2;
    localparam int CNT_OUT_W = 9;
    localparam int STEP_W    = 5;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_START,
        J_KIND_POP,
        J_FULL,
        J_EMPTY,
        J_POS_ZERO,
        J_KEY_LT_RD,
        J_LC_OUT,
        J_RC_OUT,
        J_CAND_LT_KEY,
        J_OUT_FREE
    } jcond_t;

    typedef enum logic [1:0] {
        G_ALWAYS,
        G_TAKEN,
        G_NOT_TAKEN
    } gate_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_ROOT,
        RD_LAST,
        RD_LC,
        RD_RC
    } rsel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_RDATA,
        WR_KEY,
        WR_CAND
    } wsel_t;

    typedef enum logic [2:0] {
        P_HOLD,
        P_CNT,
        P_PARENT,
        P_ZERO,
        P_CIDX
    } pos_op_t;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INC,
        C_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_INPUT,
        K_RDATA
    } key_op_t;

    typedef enum logic [1:0] {
        CD_HOLD,
        CD_LEFT,
        CD_RIGHT_MIN
    } cand_op_t;

    typedef enum logic [1:0] {
        M_HOLD,
        M_CLEAR,
        M_RDATA
    } min_op_t;

    typedef struct packed {
        jcond_t   jcond;
        gate_t    gate;
        step_t    jaddr;
        rsel_t    rsel;
        wsel_t    wsel;
        pos_op_t  pos_op;
        cnt_op_t  cnt_op;
        key_op_t  key_op;
        cand_op_t cand_op;
        min_op_t  min_op;
        logic     stat_we;
        status_t  stat;
        logic     out_load;
    } cw_t;

    typedef struct packed {
        cw_t  cw;
        logic en;
    } ctl_t;

    typedef struct packed {
        logic kind_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic key_lt_rd;
        logic lc_out;
        logic rc_out;
        logic cand_lt_key;
        logic out_free;
    } flags_t;

    localparam step_t STEP_IDLE      = 5'd0;
    localparam step_t STEP_DISPATCH  = 5'd1;
    localparam step_t STEP_INS_CHECK = 5'd2;
    localparam step_t STEP_INS_UP    = 5'd3;
    localparam step_t STEP_INS_CMP   = 5'd4;
    localparam step_t STEP_INS_WR    = 5'd5;
    localparam step_t STEP_POP_CHECK = 5'd6;
    localparam step_t STEP_POP_TAKE  = 5'd7;
    localparam step_t STEP_POP_LAST  = 5'd8;
    localparam step_t STEP_POP_LOAD  = 5'd9;
    localparam step_t STEP_DN_LEFT   = 5'd10;
    localparam step_t STEP_DN_RIGHT  = 5'd11;
    localparam step_t STEP_DN_MIN    = 5'd12;
    localparam step_t STEP_DN_CMP    = 5'd13;
    localparam step_t STEP_DN_WR     = 5'd14;
    localparam step_t STEP_FULL      = 5'd15;
    localparam step_t STEP_EMPTY     = 5'd16;
    localparam step_t STEP_OUT       = 5'd17;
    localparam step_t STEP_OUT_WAIT  = 5'd18;

    // microprogram: one control word per step
    function automatic cw_t ucode(input step_t step);
        cw_t cw;
        begin
            cw = '0;
            unique case (step)
                STEP_IDLE:
                begin
                    cw.jcond  = J_NO_START;
                    cw.jaddr  = STEP_IDLE;
                    cw.gate   = G_NOT_TAKEN;
                    cw.key_op = K_INPUT;
                    cw.min_op = M_CLEAR;
                end
                STEP_DISPATCH:
                begin
                    cw.jcond = J_KIND_POP;
                    cw.jaddr = STEP_POP_CHECK;
                end
                STEP_INS_CHECK:
                begin
                    cw.jcond  = J_FULL;
                    cw.jaddr  = STEP_FULL;
                    cw.gate   = G_NOT_TAKEN;
                    cw.pos_op = P_CNT;
                end
                STEP_INS_UP:
                begin
                    cw.jcond = J_POS_ZERO;
                    cw.jaddr = STEP_INS_WR;
                    cw.gate  = G_NOT_TAKEN;
                    cw.rsel  = RD_PARENT;
                end
                STEP_INS_CMP:
                begin
                    // larger parent moves down into the hole
                    cw.jcond  = J_KEY_LT_RD;
                    cw.jaddr  = STEP_INS_UP;
                    cw.gate   = G_TAKEN;
                    cw.wsel   = WR_RDATA;
                    cw.pos_op = P_PARENT;
                end
                STEP_INS_WR:
                begin
                    cw.jcond   = J_ALWAYS;
                    cw.jaddr   = STEP_OUT;
                    cw.wsel    = WR_KEY;
                    cw.cnt_op  = C_INC;
                    cw.stat_we = 1'b1;
                    cw.stat    = ST_INSERTED;
                end
                STEP_POP_CHECK:
                begin
                    cw.jcond = J_EMPTY;
                    cw.jaddr = STEP_EMPTY;
                    cw.gate  = G_NOT_TAKEN;
                    cw.rsel  = RD_ROOT;
                end
                STEP_POP_TAKE:
                begin
                    cw.min_op = M_RDATA;
                    cw.cnt_op = C_DEC;
                end
                STEP_POP_LAST:
                begin
                    cw.rsel = RD_LAST;
                end
                STEP_POP_LOAD:
                begin
                    cw.key_op = K_RDATA;
                    cw.pos_op = P_ZERO;
                end
                STEP_DN_LEFT:
                begin
                    cw.jcond = J_LC_OUT;
                    cw.jaddr = STEP_DN_WR;
                    cw.gate  = G_NOT_TAKEN;
                    cw.rsel  = RD_LC;
                end
                STEP_DN_RIGHT:
                begin
                    // right child read may be out of range, then its data is unused
                    cw.jcond   = J_RC_OUT;
                    cw.jaddr   = STEP_DN_CMP;
                    cw.cand_op = CD_LEFT;
                    cw.rsel    = RD_RC;
                end
                STEP_DN_MIN:
                begin
                    cw.cand_op = CD_RIGHT_MIN;
                end
                STEP_DN_CMP:
                begin
                    cw.jcond  = J_CAND_LT_KEY;
                    cw.jaddr  = STEP_DN_LEFT;
                    cw.gate   = G_TAKEN;
                    cw.wsel   = WR_CAND;
                    cw.pos_op = P_CIDX;
                end
                STEP_DN_WR:
                begin
                    cw.jcond   = J_ALWAYS;
                    cw.jaddr   = STEP_OUT;
                    cw.wsel    = WR_KEY;
                    cw.stat_we = 1'b1;
                    cw.stat    = ST_POPPED;
                end
                STEP_FULL:
                begin
                    cw.jcond   = J_ALWAYS;
                    cw.jaddr   = STEP_OUT;
                    cw.stat_we = 1'b1;
                    cw.stat    = ST_FULL;
                end
                STEP_EMPTY:
                begin
                    cw.jcond   = J_ALWAYS;
                    cw.jaddr   = STEP_OUT;
                    cw.stat_we = 1'b1;
                    cw.stat    = ST_EMPTY;
                end
                STEP_OUT:
                begin
                    cw.jcond    = J_OUT_FREE;
                    cw.jaddr    = STEP_IDLE;
                    cw.gate     = G_TAKEN;
                    cw.out_load = 1'b1;
                end
                STEP_OUT_WAIT:
                begin
                    cw.jcond = J_ALWAYS;
                    cw.jaddr = STEP_OUT;
                end
                default:
                begin
                    cw.jcond = J_ALWAYS;
                    cw.jaddr = STEP_IDLE;
                end
            endcase
            return cw;
        end
    endfunction

endpackage

>>> hdl/mhpq_ram.sv
module mhpq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mhpq_seq.sv
module mhpq_seq
    import mhpq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  flags_t flags,
    output ctl_t   ctl,
    output logic   idle
);

    step_t step_reg;
    step_t step_next;
    cw_t   cw;
    logic  taken;

    assign cw = ucode(step_reg);

    always_comb
    begin
        unique case (cw.jcond)
            J_NEXT:        taken = 1'b0;
            J_ALWAYS:      taken = 1'b1;
            J_NO_START:    taken = !start;
            J_KIND_POP:    taken = flags.kind_pop;
            J_FULL:        taken = flags.full;
            J_EMPTY:       taken = flags.empty;
            J_POS_ZERO:    taken = flags.pos_zero;
            J_KEY_LT_RD:   taken = flags.key_lt_rd;
            J_LC_OUT:      taken = flags.lc_out;
            J_RC_OUT:      taken = flags.rc_out;
            J_CAND_LT_KEY: taken = flags.cand_lt_key;
            J_OUT_FREE:    taken = flags.out_free;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = taken ? cw.jaddr : step_t'(step_reg + 1'b1);
        ctl.cw    = cw;
        unique case (cw.gate)
            G_ALWAYS:    ctl.en = 1'b1;
            G_TAKEN:     ctl.en = taken;
            G_NOT_TAKEN: ctl.en = !taken;
            default:     ctl.en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign idle = (step_reg == STEP_IDLE);

endmodule

>>> hdl/mhpq_dp.sv
module mhpq_dp
    import mhpq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 ctl,
    input  logic                 in_kind,
    input  logic [KEY_W-1:0]     in_key,
    input  logic                 out_ready,
    output flags_t               flags,
    output logic                 out_valid,
    output status_t              out_status,
    output logic [KEY_W-1:0]     out_min,
    output logic [CNT_OUT_W-1:0] out_count
);

    logic                 kind_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [KEY_W-1:0]     cand_reg;
    logic [IDX_W-1:0]     cidx_reg;
    logic [KEY_W-1:0]     min_reg;
    status_t              stat_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [KEY_W-1:0]     out_min_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;

    logic [IDX_W-1:0]   parent;
    logic [CHILD_W-1:0] lc;
    logic [CHILD_W-1:0] rc;
    logic               we;
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic [KEY_W-1:0]   wdata;
    logic [KEY_W-1:0]   rdata;
    logic               rd_lt_cand;
    cw_t                cw;

    assign cw     = ctl.cw;
    assign parent = IDX_W'((pos_reg - 1'b1) >> 1);
    assign lc     = CHILD_W'({pos_reg, 1'b1});
    assign rc     = lc + 1'b1;

    assign rd_lt_cand = $signed(rdata) < $signed(cand_reg);

    always_comb
    begin
        flags.kind_pop    = kind_reg;
        flags.full        = (cnt_reg == CNT_W'(CAPACITY));
        flags.empty       = (cnt_reg == '0);
        flags.pos_zero    = (pos_reg == '0);
        flags.key_lt_rd   = $signed(key_reg) < $signed(rdata);
        flags.lc_out      = (lc >= CHILD_W'(cnt_reg));
        flags.rc_out      = (rc >= CHILD_W'(cnt_reg));
        flags.cand_lt_key = $signed(cand_reg) < $signed(key_reg);
        flags.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        re = ctl.en && (cw.rsel != RD_NONE);
        unique case (cw.rsel)
            RD_PARENT: raddr = parent;
            RD_ROOT:   raddr = '0;
            RD_LAST:   raddr = cnt_reg[IDX_W-1:0];
            RD_LC:     raddr = lc[IDX_W-1:0];
            RD_RC:     raddr = rc[IDX_W-1:0];
            default:   raddr = '0;
        endcase
        we = ctl.en && (cw.wsel != WR_NONE);
        unique case (cw.wsel)
            WR_RDATA: wdata = rdata;
            WR_KEY:   wdata = key_reg;
            WR_CAND:  wdata = cand_reg;
            default:  wdata = key_reg;
        endcase
    end

    mhpq_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(KEY_W)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(pos_reg),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // payload registers of the working item
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            unique case (cw.key_op)
                K_INPUT:
                begin
                    key_reg  <= in_key;
                    kind_reg <= in_kind;
                end
                K_RDATA: key_reg <= rdata;
                default: ;
            endcase
            unique case (cw.pos_op)
                P_CNT:    pos_reg <= cnt_reg[IDX_W-1:0];
                P_PARENT: pos_reg <= parent;
                P_ZERO:   pos_reg <= '0;
                P_CIDX:   pos_reg <= cidx_reg;
                default:  ;
            endcase
            unique case (cw.cand_op)
                CD_LEFT:
                begin
                    cand_reg <= rdata;
                    cidx_reg <= lc[IDX_W-1:0];
                end
                CD_RIGHT_MIN:
                begin
                    // left child wins a tie
                    if (rd_lt_cand)
                    begin
                        cand_reg <= rdata;
                        cidx_reg <= rc[IDX_W-1:0];
                    end
                end
                default: ;
            endcase
            unique case (cw.min_op)
                M_CLEAR: min_reg <= '0;
                M_RDATA: min_reg <= rdata;
                default: ;
            endcase
            if (cw.stat_we)
            begin
                stat_reg <= cw.stat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.en)
        begin
            unique case (cw.cnt_op)
                C_INC:   cnt_reg <= cnt_reg + 1'b1;
                C_DEC:   cnt_reg <= cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.en && cw.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en && cw.out_load)
        begin
            out_status_reg <= stat_reg;
            out_min_reg    <= min_reg;
            out_count_reg  <= CNT_OUT_W'(cnt_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_min    = out_min_reg;
    assign out_count  = out_count_reg;

endmodule

>>> hdl/min_heap_priority_queue.sv
// empty pop or full insert: dispatch, check, the full or empty status step, the output step
// insert: dispatch, check, a parent read and compare per level the key climbs, the write
// pop: dispatch, check, take the root, read and load the last entry, then per level it sinks
// a left read, a right read, a min pick (not for a lone left child) and a compare, then the write
// one at a time, the next taken in the cycle after the result loads; a stall loops via a wait step
// reset clears the step counter, the key count and the output valid; the store is not cleared
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // min_key, count, zero fill
    output logic [1:0]  m_tuser    // status
);

    ctl_t                 ctl;
    flags_t               flags;
    logic                 idle;
    status_t              out_status;
    logic [KEY_W-1:0]     out_min;
    logic [CNT_OUT_W-1:0] out_count;

    mhpq_seq u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .start(s_tvalid),
        .flags(flags),
        .ctl  (ctl),
        .idle (idle)
    );

    mhpq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_kind   (s_tuser),
        .in_key    (s_tdata),
        .out_ready (m_tready),
        .flags     (flags),
        .out_valid (m_tvalid),
        .out_status(out_status),
        .out_min   (out_min),
        .out_count (out_count)
    );

    assign s_tready = idle;
    assign m_tuser  = out_status;
    assign m_tdata  = {{(48 - KEY_W - CNT_OUT_W){1'b0}}, out_count, out_min};

endmodule

>>> hdl/mhpq_checker.sv
module mhpq_checker
    import mhpq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_POPPED) |-> (m_tdata[31:0] == 32'd0))
        else $error("min_key nonzero without a pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[40:32] == 9'd0))
        else $error("empty pop with nonzero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[40:32] == CNT_OUT_W'(CAPACITY)))
        else $error("full insert with wrong count");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
